// File: design/bracketed_command_parser_assert.svh
// Assertion macros shared by the bracketed command parser modules.
`ifndef BRACKETED_COMMAND_PARSER_ASSERT_SVH
`define BRACKETED_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define BCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define BCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bcp_pkg.sv
// Package with the result type, character codes and token phase codes of the parser.
`timescale 1ns / 1ps
package bcp_pkg;

  typedef struct packed {
    logic [1:0]  count;
    logic [31:0] id;
    logic [31:0] arg;
  } bcp_result_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Token phases
  localparam logic [1:0] PH_SEP    = 2'd0;
  localparam logic [1:0] PH_START  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam logic [1:0] TOK_ONE = 2'd1;
  localparam logic [1:0] TOK_TWO = 2'd2;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

endpackage

// File: design/bcp_parser.sv
// Frame and token state of the parser, updated once per byte.
`timescale 1ns / 1ps
`include "bracketed_command_parser_assert.svh"
module bcp_parser
  import bcp_pkg::*;
#(
  parameter int MAX_BODY = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        emit,
  output bcp_result_t result
);

  localparam int BLW = $clog2(MAX_BODY + 1);
  localparam logic [BLW-1:0] MAX_LEN = BLW'(MAX_BODY);

  logic           in_frame_r, in_frame_nxt;
  logic [BLW-1:0] body_len_r, body_len_nxt;
  logic [1:0]     tok_idx_r, tok_idx_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic           neg_r, neg_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [31:0]    first_r, first_nxt;

  logic [1:0]  ph;
  logic [31:0] acc_base;
  logic        neg_base;
  logic        is_digit;
  logic        is_ws;

  function automatic logic [31:0] final_value(input logic [31:0] mag, input logic neg);
    logic [31:0] v;
    if (neg) begin
      v = 32'd0 - mag;
    end else begin
      v = (mag > POS_MAX) ? POS_MAX : mag;
    end
    return v;
  endfunction

  // acc * 10 + digit, saturated at 2^31
  function automatic logic [31:0] mul10_sat(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] prod;
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
    return (prod > {4'd0, MAG_CAP}) ? MAG_CAP : prod[31:0];
  endfunction

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign emit     = in_frame_r && (rx_byte == CH_GT);

  always_comb begin
    result.count = tok_idx_r;
    result.id    = 32'd0;
    result.arg   = 32'd0;
    if (tok_idx_r == TOK_ONE) begin
      result.id = final_value(acc_r, neg_r);
    end else if (tok_idx_r == TOK_TWO) begin
      result.id  = first_r;
      result.arg = final_value(acc_r, neg_r);
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    body_len_nxt = body_len_r;
    tok_idx_nxt  = tok_idx_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    acc_nxt      = acc_r;
    first_nxt    = first_r;
    ph           = phase_r;
    acc_base     = acc_r;
    neg_base     = neg_r;

    if (!in_frame_r) begin
      if (rx_byte == CH_LT) begin
        in_frame_nxt = 1'b1;
        body_len_nxt = '0;
        tok_idx_nxt  = 2'd0;
        phase_nxt    = PH_SEP;
        neg_nxt      = 1'b0;
        acc_nxt      = 32'd0;
        first_nxt    = 32'd0;
      end
    end else if (rx_byte == CH_GT) begin
      // close the frame and clear everything
      in_frame_nxt = 1'b0;
      body_len_nxt = '0;
      tok_idx_nxt  = 2'd0;
      phase_nxt    = PH_SEP;
      neg_nxt      = 1'b0;
      acc_nxt      = 32'd0;
      first_nxt    = 32'd0;
    end else if (body_len_r < MAX_LEN) begin
      if (rx_byte == CH_NUL) begin
        // a zero byte ends the counted body
        body_len_nxt = MAX_LEN;
      end else begin
        body_len_nxt = body_len_r + BLW'(1);
        if (rx_byte == CH_COLON) begin
          if (phase_r != PH_SEP && tok_idx_r == TOK_ONE) begin
            first_nxt = final_value(acc_r, neg_r);
            acc_nxt   = 32'd0;
            neg_nxt   = 1'b0;
          end
          phase_nxt = PH_SEP;
        end else if (phase_r == PH_SEP && tok_idx_r == TOK_TWO) begin
          // third and later tokens are dropped
          phase_nxt = PH_STOP;
        end else begin
          if (phase_r == PH_SEP) begin
            tok_idx_nxt = tok_idx_r + 2'd1;
            ph          = PH_START;
            acc_base    = 32'd0;
            neg_base    = 1'b0;
          end
          acc_nxt   = acc_base;
          neg_nxt   = neg_base;
          phase_nxt = ph;
          if (ph != PH_STOP) begin
            if (is_digit) begin
              acc_nxt   = mul10_sat(acc_base, rx_byte[3:0]);
              phase_nxt = PH_DIGITS;
            end else if (ph == PH_START && is_ws) begin
              phase_nxt = PH_START;
            end else if (ph == PH_START && (rx_byte == CH_PLUS || rx_byte == CH_MINUS)) begin
              neg_nxt   = (rx_byte == CH_MINUS);
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      body_len_r <= '0;
      tok_idx_r  <= 2'd0;
      phase_r    <= PH_SEP;
      neg_r      <= 1'b0;
      acc_r      <= 32'd0;
      first_r    <= 32'd0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      body_len_r <= body_len_nxt;
      tok_idx_r  <= tok_idx_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      first_r    <= first_nxt;
    end
  end

  `BCP_ASSERT_NOW(a_body_len_bound, clk, rst_n, 1'b1, body_len_r <= MAX_LEN, "body length past limit")
  `BCP_ASSERT_NOW(a_tok_idx_bound, clk, rst_n, 1'b1, tok_idx_r != 2'd3, "token index past two")
  `BCP_ASSERT_NOW(a_idle_clear, clk, rst_n, !in_frame_r, tok_idx_r == 2'd0 && acc_r == 32'd0 && body_len_r == '0, "state not clear outside frame")
  `BCP_ASSERT_NEXT(a_close_clears, clk, rst_n, step && emit, !in_frame_r && tok_idx_r == 2'd0, "frame not closed after end bracket")

endmodule

// File: design/bracketed_command_parser.sv
// Top level: input byte register, parser state and result register.
//
//  channel | ports                                          | role
//  --------+------------------------------------------------+-------------------------
//  in      | in_valid, in_ready, in_rx_byte                 | one received byte
//  out     | out_valid, out_ready, out_parsed_count,        | one result per closing '>'
//          | out_id_value, out_arg_value                    |
//
// One byte per cycle sustained unless a closing '>' waits on a stalled result; a byte's
// result (if any) is loaded into the result register as the byte leaves the input register.
// Rate is set by the combinational multiply-by-ten and saturate on the accumulator.
// Synchronous active-low reset clears the frame state and both valid flags.
// A stalled result holds only a closing '>' in the input register; other bytes
// keep flowing until such a '>' arrives, which then blocks the input until the
// result is taken.
`timescale 1ns / 1ps
`include "bracketed_command_parser_assert.svh"
module bracketed_command_parser
  import bcp_pkg::*;
#(
  parameter int MAX_BODY = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_parsed_count,
  output logic signed [31:0] out_id_value,
  output logic signed [31:0] out_arg_value
);

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        out_v_r;
  bcp_result_t out_res_r;

  logic        emit;
  logic        advance;
  logic        out_free;
  bcp_result_t res;

  bcp_parser #(
    .MAX_BODY (MAX_BODY)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .emit    (emit),
    .result  (res)
  );

  assign out_free = !out_v_r || out_ready;
  // hold a closing byte while the result register is still full
  assign advance  = in_v_r && (!emit || out_free);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_parsed_count = out_res_r.count;
  assign out_id_value     = $signed(out_res_r.id);
  assign out_arg_value    = $signed(out_res_r.arg);

  `BCP_ASSERT_NOW(a_no_overwrite, clk, rst_n, advance && emit, out_free, "result overwritten")
  `BCP_ASSERT_NOW(a_empty_ready, clk, rst_n, !in_v_r, in_ready, "empty input stage not ready")
  `BCP_ASSERT_NOW(a_count_range, clk, rst_n, out_v_r, out_res_r.count != 2'd3, "count out of range")

endmodule
